@@ sv/sfc_pkg.sv @@
// shared types, constants and the turbo color table for scalar_to_false_color
// no dependencies
package sfc_pkg;

    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int TABLE_ENTRIES = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int BYTE_BITS     = 8;
    localparam int SPAN_BITS     = 16;   // value_max - value_min when positive
    localparam int DEN_BITS      = SPAN_BITS + 1;
    localparam int NUM_BITS      = 26;   // 510 * span + span
    localparam int QUO_BITS      = 8;

    localparam logic [BYTE_BITS-1:0] BYTE_MAX = 8'd255;

    typedef logic [BYTE_BITS-1:0] byte_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE = 2'd0,
        CFG_MIN  = 2'd1,
        CFG_MAX  = 2'd2,
        CFG_NONE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_JET       = 2'd0,
        MODE_TURBO     = 2'd1,
        MODE_RED       = 2'd2,
        MODE_RED_ALPHA = 2'd3
    } mode_t;

    // jet segment along the scale
    typedef enum logic [1:0] {
        SEG_BLUE_CYAN   = 2'd0,
        SEG_CYAN_YELLOW = 2'd1,
        SEG_YELLOW_RED  = 2'd2,
        SEG_RED_DARK    = 2'd3
    } seg_t;

    // turbo index source
    typedef enum logic [1:0] {
        TSEL_RATIO = 2'd0,
        TSEL_FIRST = 2'd1,
        TSEL_LAST  = 2'd2,
        TSEL_SPARE = 2'd3
    } tsel_t;

    // word riding alongside the divider
    typedef struct packed {
        mode_t mode;
        seg_t  seg;
        tsel_t tsel;
    } side_t;

    localparam byte_t TURBO_ROM [TABLE_ENTRIES][3] = '{
 '{48,18,59},'{50,21,67},'{51,24,74},'{52,27,81},'{53,30,88},'{54,33,95},'{55,36,102},'{56,39,109},
 '{57,42,115},'{58,45,121},'{59,47,128},'{60,50,134},'{61,53,139},'{62,56,145},'{63,59,151},
 '{63,62,156},
 '{64,64,162},'{65,67,167},'{65,70,172},'{66,73,177},'{66,75,181},'{67,78,186},'{68,81,191},
 '{68,84,195},
 '{68,86,199},'{69,89,203},'{69,92,207},'{69,94,211},'{70,97,214},'{70,100,218},'{70,102,221},
 '{70,105,224},
 '{70,107,227},'{71,110,230},'{71,113,233},'{71,115,235},'{71,118,238},'{71,120,240},
 '{71,123,242},'{70,125,244},
 '{70,128,246},'{70,130,248},'{70,133,250},'{70,135,251},'{69,138,252},'{69,140,253},
 '{68,143,254},'{67,145,254},
 '{66,148,255},'{65,150,255},'{64,153,255},'{62,155,254},'{61,158,254},'{59,160,253},
 '{58,163,252},'{56,165,251},
 '{55,168,250},'{53,171,248},'{51,173,247},'{49,175,245},'{47,178,244},'{46,180,242},
 '{44,183,240},'{42,185,238},
 '{40,188,235},'{39,190,233},'{37,192,231},'{35,195,228},'{34,197,226},'{32,199,223},
 '{31,201,221},'{30,203,218},
 '{28,205,216},'{27,208,213},'{26,210,210},'{26,212,208},'{25,213,205},'{24,215,202},
 '{24,217,200},'{24,219,197},
 '{24,221,194},'{24,222,192},'{24,224,189},'{25,226,187},'{25,227,185},'{26,228,182},
 '{28,230,180},'{29,231,178},
 '{31,233,175},'{32,234,172},'{34,235,170},'{37,236,167},'{39,238,164},'{42,239,161},
 '{44,240,158},'{47,241,155},
 '{50,242,152},'{53,243,148},'{56,244,145},'{60,245,142},'{63,246,138},'{67,247,135},
 '{70,248,132},'{74,248,128},
 '{78,249,125},'{82,250,122},'{85,250,118},'{89,251,115},'{93,252,111},'{97,252,108},
 '{101,253,105},'{105,253,102},
 '{109,254,98},'{113,254,95},'{117,254,92},'{121,254,89},'{125,255,86},'{128,255,83},
 '{132,255,81},'{136,255,78},
 '{139,255,75},'{143,255,73},'{146,255,71},'{150,254,68},'{153,254,66},'{156,254,64},
 '{159,253,63},'{161,253,61},
 '{164,252,60},'{167,252,58},'{169,251,57},'{172,251,56},'{175,250,55},'{177,249,54},
 '{180,248,54},'{183,247,53},
 '{185,246,53},'{188,245,52},'{190,244,52},'{193,243,52},'{195,241,52},'{198,240,52},
 '{200,239,52},'{203,237,52},
 '{205,236,52},'{208,234,52},'{210,233,53},'{212,231,53},'{215,229,53},'{217,228,54},
 '{219,226,54},'{221,224,55},
 '{223,223,55},'{225,221,55},'{227,219,56},'{229,217,56},'{231,215,57},'{233,213,57},
 '{235,211,57},'{236,209,58},
 '{238,207,58},'{239,205,58},'{241,203,58},'{242,201,58},'{244,199,58},'{245,197,58},
 '{246,195,58},'{247,193,58},
 '{248,190,57},'{249,188,57},'{250,186,57},'{251,184,56},'{251,182,55},'{252,179,54},
 '{252,177,54},'{253,174,53},
 '{253,172,52},'{254,169,51},'{254,167,50},'{254,164,49},'{254,161,48},'{254,158,47},
 '{254,155,45},'{254,153,44},
 '{254,150,43},'{254,147,42},'{254,144,41},'{253,141,39},'{253,138,38},'{252,135,37},
 '{252,132,35},'{251,129,34},
 '{251,126,33},'{250,123,31},'{249,120,30},'{249,117,29},'{248,114,28},'{247,111,26},
 '{246,108,25},'{245,105,24},
 '{244,102,23},'{243,99,21},'{242,96,20},'{241,93,19},'{240,91,18},'{239,88,17},
 '{237,85,16},'{236,83,15},
 '{235,80,14},'{234,78,13},'{232,75,12},'{231,73,12},'{229,71,11},'{228,69,10},
 '{226,67,10},'{225,65,9},
 '{223,63,8},'{221,61,8},'{220,59,7},'{218,57,7},'{216,55,6},'{214,53,6},'{212,51,5},
 '{210,49,5},
 '{208,47,5},'{206,45,4},'{204,43,4},'{202,42,4},'{200,40,3},'{197,38,3},'{195,37,3},
 '{193,35,2},
 '{190,33,2},'{188,32,2},'{185,30,2},'{183,29,2},'{180,27,1},'{178,26,1},'{175,24,1},
 '{172,23,1},
 '{169,22,1},'{167,20,1},'{164,19,1},'{161,18,1},'{158,16,1},'{155,15,1},'{152,14,1},
 '{149,13,1},
 '{146,11,1},'{142,10,1},'{139,9,2},'{136,8,2},'{133,7,2},'{129,6,2},'{126,5,2},'{122,4,3}
    };

endpackage

@@ sv/sfc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, side word carried along
// depends on sfc_pkg
module sfc_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic [sfc_pkg::NUM_BITS-1:0]      in_num,
    input  logic [sfc_pkg::DEN_BITS-1:0]      in_den,
    input  sfc_pkg::side_t                    in_side,
    output logic                              out_vld,
    output logic [sfc_pkg::QUO_BITS-1:0]      out_quo,
    output sfc_pkg::side_t                    out_side
);

    localparam int STEPS = sfc_pkg::QUO_BITS;

    logic                         vld_reg  [STEPS];
    logic [sfc_pkg::NUM_BITS-1:0] rem_reg  [STEPS];
    logic [sfc_pkg::DEN_BITS-1:0] den_reg  [STEPS];
    logic [sfc_pkg::QUO_BITS-1:0] quo_reg  [STEPS];
    sfc_pkg::side_t               side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic                         vld_in;
            logic [sfc_pkg::NUM_BITS-1:0] rem_in;
            logic [sfc_pkg::DEN_BITS-1:0] den_in;
            logic [sfc_pkg::QUO_BITS-1:0] quo_in;
            sfc_pkg::side_t               side_in;
            logic [sfc_pkg::NUM_BITS-1:0] shifted;
            logic                         fits;
            logic [sfc_pkg::NUM_BITS-1:0] rem_next;
            logic [sfc_pkg::QUO_BITS-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign rem_in  = in_num;
                assign den_in  = in_den;
                assign quo_in  = '0;
                assign side_in = in_side;
            end
            else
            begin : g_rest
                assign vld_in  = vld_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign quo_in  = quo_reg[k-1];
                assign side_in = side_reg[k-1];
            end

            // trial subtract of the divisor at bit weight STEPS-1-k
            assign shifted  = sfc_pkg::NUM_BITS'(den_in) << (STEPS - 1 - k);
            assign fits     = rem_in >= shifted;
            assign rem_next = fits ? rem_in - shifted : rem_in;
            assign quo_next = {quo_in[sfc_pkg::QUO_BITS-2:0], fits};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STEPS-1];
    assign out_quo  = quo_reg[STEPS-1];
    assign out_side = side_reg[STEPS-1];

endmodule

@@ sv/scalar_to_false_color.sv @@
// top level of the false color mapper: range clamp, jet segment, divider, color assembly
// depends on sfc_pkg and sfc_div
//
// usage
//   - configuration: cfg_write with cfg_index (0 map_mode, 1 value_min, 2 value_max)
//     and cfg_data; the word is taken at the same edge, index 3 is ignored. write only
//     while no sample is in flight
//   - input: a sample word is taken at every edge with start high and busy low; busy is
//     always low, so one sample per clock is sustained
//   - output: red, green, blue, alpha are valid for exactly one cycle with done high;
//     done rises once the sample has passed the clamp, numerator, divider and output
//     registers; the receiver cannot stall, there is no backpressure and the pipeline
//     never holds
//   - pipeline: clamp and span (1), segment and numerator (2), eight divider stages
//     giving one quotient bit each (3..10), table lookup and color assembly (11)
//   - the divider sets the latency: round(255 n / d) needs 8 quotient bits
//   - reset clears the valid bits and loads map_mode jet, value_min 0, value_max 32767
module scalar_to_false_color
#(
    parameter int SAMPLE_BITS = sfc_pkg::SAMPLE_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             cfg_write,
    input  logic [sfc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [sfc_pkg::CFG_BITS-1:0]     cfg_data,
    output logic                             done,
    output logic [sfc_pkg::BYTE_BITS-1:0]    red,
    output logic [sfc_pkg::BYTE_BITS-1:0]    green,
    output logic [sfc_pkg::BYTE_BITS-1:0]    blue,
    output logic [sfc_pkg::BYTE_BITS-1:0]    alpha
);

    // common signed width for sample and range compares
    localparam int EXT_BITS =
        (SAMPLE_BITS > sfc_pkg::CFG_BITS ? SAMPLE_BITS : sfc_pkg::CFG_BITS) + 1;
    localparam int LATENCY = 3 + sfc_pkg::QUO_BITS;

    // configuration registers
    sfc_pkg::mode_t                     mode_reg;
    logic signed [sfc_pkg::CFG_BITS-1:0] min_reg;
    logic signed [sfc_pkg::CFG_BITS-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sfc_pkg::MODE_JET;
            min_reg  <= '0;
            max_reg  <= 16'sd32767;
        end
        else if (cfg_write)
        begin
            case (sfc_pkg::cfg_idx_t'(cfg_index))
                sfc_pkg::CFG_MODE: mode_reg <= sfc_pkg::mode_t'(cfg_data[1:0]);
                sfc_pkg::CFG_MIN:  min_reg  <= cfg_data;
                sfc_pkg::CFG_MAX:  max_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: clamp into range, p = clamped - min, d = max - min (p = 0, d = 1 if max <= min)
    logic signed [EXT_BITS-1:0]         smp_x, min_x, max_x, clamp_x, off_x;
    logic signed [sfc_pkg::CFG_BITS:0]  span_x;
    logic                               rng_ok;
    logic [sfc_pkg::SPAN_BITS-1:0]      p_next, d_next;

    assign smp_x  = EXT_BITS'(sample);
    assign min_x  = EXT_BITS'(min_reg);
    assign max_x  = EXT_BITS'(max_reg);
    assign span_x = (sfc_pkg::CFG_BITS+1)'(max_reg) - (sfc_pkg::CFG_BITS+1)'(min_reg);
    assign rng_ok = span_x > 0;
    assign clamp_x = (smp_x < min_x) ? min_x : ((smp_x > max_x) ? max_x : smp_x);
    assign off_x   = clamp_x - min_x;
    assign p_next  = rng_ok ? off_x[sfc_pkg::SPAN_BITS-1:0] : '0;
    assign d_next  = rng_ok ? span_x[sfc_pkg::SPAN_BITS-1:0] : sfc_pkg::SPAN_BITS'(1);

    logic                          a_vld_reg;
    logic [sfc_pkg::SPAN_BITS-1:0] a_p_reg, a_d_reg;
    logic                          a_le_reg, a_ge_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg  <= p_next;
        a_d_reg  <= d_next;
        a_le_reg <= smp_x <= min_x;
        a_ge_reg <= smp_x >= max_x;
    end

    // stage 2: jet segment (q = 4p against d, 2d, 3d) and rounding numerator 510n + d
    localparam int QW = sfc_pkg::SPAN_BITS + 2;
    logic [QW-1:0]                 q4, d1, d2, d3, d4;
    logic [QW-1:0]                 n_wide;
    logic [sfc_pkg::SPAN_BITS-1:0] n_sel;
    sfc_pkg::seg_t                 seg;
    sfc_pkg::tsel_t                tsel;
    sfc_pkg::side_t                side_next;
    logic [sfc_pkg::NUM_BITS-1:0]  num_next;

    assign q4 = {a_p_reg, 2'b00};
    assign d1 = QW'(a_d_reg);
    assign d2 = {1'b0, a_d_reg, 1'b0};
    assign d3 = d1 + d2;
    assign d4 = {a_d_reg, 2'b00};

    always_comb
    begin
        if (q4 < d1)
        begin
            seg    = sfc_pkg::SEG_BLUE_CYAN;
            n_wide = q4;
        end
        else if (q4 < d2)
        begin
            seg    = sfc_pkg::SEG_CYAN_YELLOW;
            n_wide = d2 - q4;
        end
        else if (q4 < d3)
        begin
            seg    = sfc_pkg::SEG_YELLOW_RED;
            n_wide = q4 - d2;
        end
        else
        begin
            seg    = sfc_pkg::SEG_RED_DARK;
            n_wide = d4 - q4;
        end
    end

    // every map but jet divides p itself
    assign n_sel = (mode_reg == sfc_pkg::MODE_JET) ? n_wide[sfc_pkg::SPAN_BITS-1:0] : a_p_reg;

    assign tsel = a_le_reg ? sfc_pkg::TSEL_FIRST :
                  (a_ge_reg ? sfc_pkg::TSEL_LAST : sfc_pkg::TSEL_RATIO);

    assign num_next = (sfc_pkg::NUM_BITS'(n_sel) << 9) - (sfc_pkg::NUM_BITS'(n_sel) << 1)
                      + sfc_pkg::NUM_BITS'(a_d_reg);

    assign side_next = '{mode: mode_reg, seg: seg, tsel: tsel};

    logic                         b_vld_reg;
    logic [sfc_pkg::NUM_BITS-1:0] b_num_reg;
    logic [sfc_pkg::DEN_BITS-1:0] b_den_reg;
    sfc_pkg::side_t               b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_num_reg  <= num_next;
        b_den_reg  <= {a_d_reg, 1'b0};
        b_side_reg <= side_next;
    end

    // stages 3 to 10: quotient floor((510n + d) / 2d)
    logic                         c_vld;
    logic [sfc_pkg::QUO_BITS-1:0] c_quo;
    sfc_pkg::side_t               c_side;

    sfc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (b_vld_reg),
        .in_num   (b_num_reg),
        .in_den   (b_den_reg),
        .in_side  (b_side_reg),
        .out_vld  (c_vld),
        .out_quo  (c_quo),
        .out_side (c_side)
    );

    // stage 11: table lookup and color assembly
    logic [sfc_pkg::BYTE_BITS-1:0] t_idx;
    sfc_pkg::byte_t                r_next, g_next, b_next, al_next;

    always_comb
    begin
        case (c_side.tsel)
            sfc_pkg::TSEL_FIRST: t_idx = '0;
            sfc_pkg::TSEL_LAST:  t_idx = sfc_pkg::BYTE_BITS'(sfc_pkg::TABLE_ENTRIES - 1);
            default:             t_idx = c_quo;
        endcase
    end

    always_comb
    begin
        r_next  = '0;
        g_next  = '0;
        b_next  = '0;
        al_next = sfc_pkg::BYTE_MAX;
        case (c_side.mode)
            sfc_pkg::MODE_JET:
            begin
                case (c_side.seg)
                    sfc_pkg::SEG_BLUE_CYAN:
                    begin
                        g_next = c_quo;
                        b_next = sfc_pkg::BYTE_MAX;
                    end
                    sfc_pkg::SEG_CYAN_YELLOW:
                    begin
                        g_next = sfc_pkg::BYTE_MAX;
                        b_next = c_quo;
                    end
                    sfc_pkg::SEG_YELLOW_RED:
                    begin
                        r_next = c_quo;
                        g_next = sfc_pkg::BYTE_MAX;
                    end
                    default:
                    begin
                        r_next = sfc_pkg::BYTE_MAX;
                        g_next = c_quo;
                    end
                endcase
            end
            sfc_pkg::MODE_TURBO:
            begin
                r_next = sfc_pkg::TURBO_ROM[t_idx][0];
                g_next = sfc_pkg::TURBO_ROM[t_idx][1];
                b_next = sfc_pkg::TURBO_ROM[t_idx][2];
            end
            sfc_pkg::MODE_RED:
            begin
                r_next  = c_quo;
                al_next = c_quo;
            end
            default:
            begin
                r_next  = sfc_pkg::BYTE_MAX;
                al_next = c_quo;
            end
        endcase
    end

    logic done_reg;
    sfc_pkg::byte_t red_reg, green_reg, blue_reg, alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= r_next;
        green_reg <= g_next;
        blue_reg  <= b_next;
        alpha_reg <= al_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

    // every accepted sample gives a word after the fixed latency, and nothing else does
    a_latency_in: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("sample lost in pipeline");

    a_latency_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result word without a sample");

    // jet and turbo words are opaque
    a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mode_reg == sfc_pkg::MODE_JET || mode_reg == sfc_pkg::MODE_TURBO))
        |-> alpha == sfc_pkg::BYTE_MAX)
        else $error("alpha not opaque for jet or turbo");

    // red ramp carries the same ratio in red and alpha
    a_red_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_reg == sfc_pkg::MODE_RED) |-> (red == alpha && green == '0))
        else $error("red ramp channels disagree");

endmodule
